// ----- rtl/core/icmp_nat_translation_table_top_macros.svh -----
// Assertion helpers for the ICMP NAT table, clocked on clk, held off in reset.
`ifndef ICMP_NAT_TRANSLATION_TABLE_TOP_MACROS_SVH
`define ICMP_NAT_TRANSLATION_TABLE_TOP_MACROS_SVH

// Property that holds on every cycle out of reset.
`define NAT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger in one cycle implies the outcome in the next.
`define NAT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/icmp_nat_pkg.sv -----
package icmp_nat_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int ADDR_W            = 32;
  localparam int IDENT_W           = 16;
  localparam int CSUM_W            = 16;

  // action codes
  localparam logic ACT_SNAT = 1'b0;
  localparam logic ACT_DNAT = 1'b1;

  typedef struct packed {
    logic               action;
    logic [IDENT_W-1:0] icmp_ident;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [CSUM_W-1:0]  hdr_checksum;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] out_src_addr;
    logic [ADDR_W-1:0] out_dst_addr;
    logic [CSUM_W-1:0] out_checksum;
    logic              translated;
  } out_item_t;

  // lookup token passed cell to cell
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } tok_t;

endpackage

// ----- rtl/core/icmp_nat_cell.sv -----
module icmp_nat_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [icmp_nat_pkg::IDENT_W-1:0]    wr_ident,
  input  logic [icmp_nat_pkg::ADDR_W-1:0]     wr_addr,
  input  logic [icmp_nat_pkg::IDENT_W-1:0]    key,
  input  icmp_nat_pkg::tok_t                  tok_in,
  output icmp_nat_pkg::tok_t                  tok_out
);
  import icmp_nat_pkg::*;

  logic               valid_r;
  logic [IDENT_W-1:0] ident_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               tok_vld_r, tok_hit_r;
  logic [ADDR_W-1:0]  tok_addr_r;
  logic               match;

  // first match along the chain wins
  assign match = tok_in.vld && !tok_in.hit && valid_r && (ident_r == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
      tok_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end
      tok_vld_r <= tok_in.vld;
      tok_hit_r <= tok_in.hit || match;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ident_r <= wr_ident;
      addr_r  <= wr_addr;
    end
    tok_addr_r <= match ? addr_r : tok_in.addr;
  end

  assign tok_out = '{vld: tok_vld_r, hit: tok_hit_r, addr: tok_addr_r};

endmodule

// ----- rtl/core/icmp_nat_csum.sv -----
module icmp_nat_csum (
  input  logic [icmp_nat_pkg::CSUM_W-1:0] hc,
  input  logic [icmp_nat_pkg::ADDR_W-1:0] old_addr,
  input  logic [icmp_nat_pkg::ADDR_W-1:0] new_addr,
  output logic [icmp_nat_pkg::CSUM_W-1:0] csum
);
  import icmp_nat_pkg::*;

  // five 16-bit terms fit in 19 bits
  localparam int SUM_W = CSUM_W + 3;

  logic [CSUM_W-1:0] n_hc, n_hi, n_lo;
  logic [SUM_W-1:0]  sum0;
  logic [CSUM_W:0]   sum1;
  logic [CSUM_W-1:0] sum2;

  // HC' = ~(~HC + ~m + m'), one's complement
  // inversions are kept at 16 bits before widening
  always_comb begin
    n_hc = ~hc;
    n_hi = ~old_addr[ADDR_W-1:CSUM_W];
    n_lo = ~old_addr[CSUM_W-1:0];
    sum0 = SUM_W'(n_hc)
         + SUM_W'(n_hi)
         + SUM_W'(n_lo)
         + SUM_W'(new_addr[ADDR_W-1:CSUM_W])
         + SUM_W'(new_addr[CSUM_W-1:0]);
    sum1 = (CSUM_W+1)'(sum0[CSUM_W-1:0]) + (CSUM_W+1)'(sum0[SUM_W-1:CSUM_W]);
    sum2 = sum1[CSUM_W-1:0] + CSUM_W'(sum1[CSUM_W]);
    csum = ~sum2;
  end

endmodule

// ----- rtl/core/icmp_nat_translation_table_top.sv -----
// ICMP identifier NAT table. One IPv4 ICMP header summary is taken per
// transfer on the in_ channel and one rewritten header leaves per transfer on
// the out_ channel. An outbound item (action 0) stores its identifier and
// source address in the next slot of a ring of TABLE_ENTRIES slots (the
// oldest slot is overwritten once the ring is full) and gets cfg_wdata's
// public address as its new source. An inbound item (action 1) looks up its
// identifier among the valid slots; the lowest-numbered match supplies the new
// destination, and on a miss the header passes unchanged with translated low.
// The checksum is updated incrementally (RFC 1624), so an unchanged address
// still turns a checksum of 0xFFFF into 0x0000. The table is a row of cells,
// one slot per cell, and a lookup token walks the row one cell per clock.
// Items are handled one at a time: the next item is taken only once the last
// result has moved into the output register; an inbound item first waits for
// the token to walk the whole cell row, and a stalled output holds the block
// busy. Write public_addr only while the block is idle.
`include "icmp_nat_translation_table_top_macros.svh"

module icmp_nat_translation_table_top #(
  parameter int TABLE_ENTRIES = icmp_nat_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  icmp_nat_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output icmp_nat_pkg::out_item_t         out_data,
  input  logic                            cfg_we,
  input  logic [icmp_nat_pkg::ADDR_W-1:0] cfg_wdata
);
  import icmp_nat_pkg::*;

  localparam int PTR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // control
  logic              busy_r;     // an item is in flight
  logic              pend_r;     // result ready for the output register
  logic              start_r;    // inject lookup token into the row
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              out_valid_r;

  // payload
  logic [ADDR_W-1:0] public_addr_r;
  in_item_t          item_r;
  logic              hit_r;
  logic [ADDR_W-1:0] res_addr_r;
  out_item_t         out_r;

  logic              in_xfer, out_load, snat_go, tok_done;
  logic [CSUM_W-1:0] new_csum;
  logic [ADDR_W-1:0] old_addr;
  tok_t              tok_w [0:TABLE_ENTRIES];

  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;
  assign snat_go  = in_xfer && (in_data.action == ACT_SNAT);
  assign tok_done = tok_w[TABLE_ENTRIES].vld;
  // result moves out once the output register is free or being emptied
  assign out_load = pend_r && (!out_valid_r || !out_stall);

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(TABLE_ENTRIES - 1)) ? '0 : wr_ptr_r + 1'b1;

  // -------------------------------------------------------------------------
  // Cell row: token enters cell 0 the cycle after the inbound transfer so the
  // key is already registered; each cell keeps the first hit it sees.
  // -------------------------------------------------------------------------
  assign tok_w[0] = '{vld: start_r, hit: 1'b0, addr: '0};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    icmp_nat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (snat_go && (wr_ptr_r == PTR_W'(i))),
      .wr_ident (in_data.icmp_ident),
      .wr_addr  (in_data.src_addr),
      .key      (item_r.icmp_ident),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      pend_r        <= 1'b0;
      start_r       <= 1'b0;
      wr_ptr_r      <= '0;
      out_valid_r   <= 1'b0;
      public_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        public_addr_r <= cfg_wdata;
      end
      start_r <= in_xfer && (in_data.action == ACT_DNAT);
      if (snat_go) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (snat_go || tok_done) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (snat_go) begin
      hit_r      <= 1'b1;
      res_addr_r <= public_addr_r;
    end else if (tok_done) begin
      hit_r      <= tok_w[TABLE_ENTRIES].hit;
      res_addr_r <= tok_w[TABLE_ENTRIES].addr;
    end
    if (out_load) begin
      out_r.out_src_addr <= (item_r.action == ACT_SNAT) ? res_addr_r : item_r.src_addr;
      out_r.out_dst_addr <= (item_r.action == ACT_DNAT && hit_r) ? res_addr_r
                                                                  : item_r.dst_addr;
      out_r.out_checksum <= hit_r ? new_csum : item_r.hdr_checksum;
      out_r.translated   <= hit_r;
    end
  end

  // checksum of the address that changes
  assign old_addr = (item_r.action == ACT_SNAT) ? item_r.src_addr : item_r.dst_addr;

  icmp_nat_csum u_csum (
    .hc       (item_r.hdr_checksum),
    .old_addr (old_addr),
    .new_addr (res_addr_r),
    .csum     (new_csum)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `NAT_ASSERT(a_pend_busy, !pend_r || busy_r, "result pending with no item in flight")
  `NAT_ASSERT(a_tok_busy, !tok_done || (busy_r && !pend_r), "lookup token outside a search")
  `NAT_ASSERT_NEXT(a_load_out, out_load, out_valid_r && !busy_r, "result load lost")
  `NAT_ASSERT_NEXT(a_snat_pend, snat_go, pend_r && hit_r, "outbound item not finished")

endmodule
